@@ design/btip_pkg.sv @@
package btip_pkg;

  localparam int POINTS_DEF = 16;
  localparam int VW_DEF     = 16;

  localparam logic [1:0] MODE_LEFT    = 2'd0;
  localparam logic [1:0] MODE_RIGHT   = 2'd1;
  localparam logic [1:0] MODE_NEAREST = 2'd2;
  localparam logic [1:0] MODE_LINEAR  = 2'd3;

  localparam logic [1:0] RANGE_IN   = 2'd0;
  localparam logic [1:0] RANGE_LOW  = 2'd1;
  localparam logic [1:0] RANGE_HIGH = 2'd2;

  localparam logic [1:0] REG_INTERP = 2'd0;
  localparam logic [1:0] REG_EDGE   = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // data lanes carried along the cell row
  localparam int D_QX = 0;
  localparam int D_LX = 1;
  localparam int D_LY = 2;
  localparam int D_X0 = 3;
  localparam int D_Y0 = 4;
  localparam int D_X1 = 5;
  localparam int D_Y1 = 6;
  localparam int D_FX = 7;
  localparam int D_FY = 8;
  localparam int D_EX = 9;
  localparam int D_EY = 10;
  localparam int DN   = 11;

  typedef struct packed {
    logic valid;
    logic hit;
  } tok_t;

endpackage

@@ design/breakpoint_table_interpolator_unit.sv @@
// channel | direction | handshake            | words
// in_     | input     | in_valid / in_stall  | write breakpoint or query
// out_    | output    | out_valid / out_stall| one per query
// cfg_    | input     | APB write/read       | interp_mode, edge_mode, point_count
// A write word is stored in its cell when taken. A query walks the cell row one cell per cycle;
// step, nearest and edge results are ready at its end; linear adds a multiply
// state (S_MUL) and the shift-subtract divider (S_DIV) before the result.
// Input is stalled while a query is in flight; a finished word waits in the
// output register while the next input word is taken.
// Reset (synchronous, rst_n low) sets control regs; table and data stay undefined.
module breakpoint_table_interpolator_unit #(
  parameter int POINTS = btip_pkg::POINTS_DEF,
  parameter int VW     = btip_pkg::VW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [3:0]            in_point_index,
  input  logic signed [VW-1:0]  in_point_x,
  input  logic signed [VW-1:0]  in_point_y,
  input  logic signed [VW-1:0]  in_query_x,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [VW-1:0]  out_result_value,
  output logic [1:0]            out_range_status,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import btip_pkg::*;

  localparam int CW  = $clog2(POINTS + 1);
  localparam int PW  = 2 * VW + 2;
  localparam int DCW = $clog2(PW + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0] interp_mode_r;
  logic       edge_mode_r;
  logic [4:0] point_count_r;
  logic       cfg_wr;

  logic [CW-1:0] cnt;
  logic          in_acc, w_acc, q_acc;

  tok_t                  tok_w [POINTS+1];
  logic [DN-1:0][VW-1:0] dat_w [POINTS+1];

  logic signed [VW-1:0] res_r, res_nxt, y0_r, y0_nxt;
  logic [1:0]           stat_r, stat_nxt;
  logic                 lin_r, lin_nxt, neg_r, neg_nxt;
  logic [VW:0]          span_r, span_nxt, off_r, off_nxt, mdy_r, mdy_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [VW+1:0]        rem_r, rem_nxt, trial;
  logic [DCW-1:0]       dcnt_r, dcnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] out_val_r;
  logic [1:0]           out_stat_r;
  logic                 out_load;

  logic signed [VW-1:0] t_qx, t_x0, t_y0, t_x1, t_y1;
  logic signed [VW:0]   t_span, t_off, t_dy;
  logic signed [VW+1:0] t_two_q, t_mid;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_mode_r <= MODE_LINEAR;
      edge_mode_r   <= 1'b0;
      point_count_r <= 5'd2;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_INTERP: interp_mode_r <= cfg_pwdata[1:0];
        REG_EDGE:   edge_mode_r   <= cfg_pwdata[0];
        REG_COUNT:  point_count_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_INTERP: cfg_prdata = {30'd0, interp_mode_r};
      REG_EDGE:   cfg_prdata = {31'd0, edge_mode_r};
      REG_COUNT:  cfg_prdata = {27'd0, point_count_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (point_count_r < 5'd2) begin
      cnt = CW'(2);
    end else if (32'(point_count_r) > POINTS) begin
      cnt = CW'(POINTS);
    end else begin
      cnt = CW'(point_count_r);
    end
  end

  // input side
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign w_acc    = in_acc & (in_req_type == REQ_WRITE);
  assign q_acc    = in_acc & (in_req_type == REQ_QUERY);

  always_comb begin
    tok_w[0]       = '{valid: q_acc, hit: 1'b0};
    dat_w[0]       = '0;
    dat_w[0][D_QX] = in_query_x;
  end

  for (genvar g = 0; g < POINTS; g++) begin : g_cell
    btip_cell #(.VW(VW), .CW(CW), .IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .wr_en (w_acc && (32'(in_point_index) == g)),
      .wr_x  (in_point_x),
      .wr_y  (in_point_y),
      .cnt   (cnt),
      .tok_i (tok_w[g]),
      .dat_i (dat_w[g]),
      .tok_o (tok_w[g+1]),
      .dat_o (dat_w[g+1])
    );
  end

  // evaluation at the end of the row
  assign t_qx    = $signed(dat_w[POINTS][D_QX]);
  assign t_x0    = $signed(dat_w[POINTS][D_X0]);
  assign t_y0    = $signed(dat_w[POINTS][D_Y0]);
  assign t_x1    = $signed(dat_w[POINTS][D_X1]);
  assign t_y1    = $signed(dat_w[POINTS][D_Y1]);
  assign t_span  = (VW+1)'(t_x1) - (VW+1)'(t_x0);
  assign t_off   = (VW+1)'(t_qx) - (VW+1)'(t_x0);
  assign t_dy    = (VW+1)'(t_y1) - (VW+1)'(t_y0);
  assign t_two_q = (VW+2)'(t_qx) <<< 1;
  assign t_mid   = (VW+2)'(t_x0) + (VW+2)'(t_x1);

  assign trial = {rem_r[VW:0], prod_r[PW-1]};

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    lin_nxt   = lin_r;
    neg_nxt   = neg_r;
    y0_nxt    = y0_r;
    span_nxt  = span_r;
    off_nxt   = off_r;
    mdy_nxt   = mdy_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_acc) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_w[POINTS].valid) begin
          lin_nxt   = 1'b0;
          state_nxt = S_DONE;
          if (t_qx <= $signed(dat_w[POINTS][D_FX])) begin
            stat_nxt = RANGE_LOW;
            res_nxt  = edge_mode_r ? '0 : $signed(dat_w[POINTS][D_FY]);
          end else if (t_qx > $signed(dat_w[POINTS][D_EX])) begin
            stat_nxt = RANGE_HIGH;
            res_nxt  = edge_mode_r ? '0 : $signed(dat_w[POINTS][D_EY]);
          end else begin
            stat_nxt = RANGE_IN;
            if (!tok_w[POINTS].hit) begin
              res_nxt = $signed(dat_w[POINTS][D_EY]);
            end else begin
              unique case (interp_mode_r)
                MODE_LEFT:    res_nxt = t_y0;
                MODE_RIGHT:   res_nxt = t_y1;
                MODE_NEAREST: res_nxt = (t_two_q > t_mid) ? t_y1 : t_y0;
                default: begin
                  res_nxt = t_y0;
                  if (t_span > 0 && t_off >= 0) begin
                    lin_nxt   = 1'b1;
                    y0_nxt    = t_y0;
                    neg_nxt   = t_dy[VW];
                    mdy_nxt   = t_dy[VW] ? (VW+1)'(-t_dy) : t_dy;
                    span_nxt  = t_span;
                    off_nxt   = t_off;
                    state_nxt = S_MUL;
                  end
                end
              endcase
            end
          end
        end
      end
      S_MUL: begin
        prod_nxt  = PW'(mdy_r) * PW'(off_r);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (trial >= {1'b0, span_r}) begin
          rem_nxt  = trial - {1'b0, span_r};
          prod_nxt = {prod_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt  = trial;
          prod_nxt = {prod_r[PW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(PW - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dcnt_r      <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
    lin_r  <= lin_nxt;
    neg_r  <= neg_nxt;
    y0_r   <= y0_nxt;
    span_r <= span_nxt;
    off_r  <= off_nxt;
    mdy_r  <= mdy_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    if (out_load) begin
      out_stat_r <= stat_r;
      if (lin_r) begin
        out_val_r <= neg_r ? (y0_r - $signed(prod_r[VW-1:0]))
                           : (y0_r + $signed(prod_r[VW-1:0]));
      end else begin
        out_val_r <= res_r;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_range_status = out_stat_r;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside done state");
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[POINTS].valid |-> state_r == S_SCAN)
    else $error("query left the cell row outside scan");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dcnt_r < DCW'(PW))
    else $error("divider step count overrun");
`endif

endmodule

@@ design/btip_cell.sv @@
module btip_cell #(
  parameter int VW  = btip_pkg::VW_DEF,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [VW-1:0]                  wr_x,
  input  logic [VW-1:0]                  wr_y,
  input  logic [CW-1:0]                  cnt,
  input  btip_pkg::tok_t                 tok_i,
  input  logic [btip_pkg::DN-1:0][VW-1:0] dat_i,
  output btip_pkg::tok_t                 tok_o,
  output logic [btip_pkg::DN-1:0][VW-1:0] dat_o
);
  import btip_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [VW-1:0]          x_r, y_r;
  tok_t                   tok_r, tok_nxt;
  logic [DN-1:0][VW-1:0]  dat_r, dat_nxt;

  always_comb begin
    tok_nxt = tok_i;
    dat_nxt = dat_i;
    dat_nxt[D_LX] = x_r;
    dat_nxt[D_LY] = y_r;
    if (IDX == 0) begin
      dat_nxt[D_FX] = x_r;
      dat_nxt[D_FY] = y_r;
    end
    if (IDX_C == cnt - CW'(1)) begin
      dat_nxt[D_EX] = x_r;
      dat_nxt[D_EY] = y_r;
    end
    if (IDX != 0 && IDX_C < cnt && tok_i.valid && !tok_i.hit &&
        $signed(dat_i[D_QX]) < $signed(x_r)) begin
      tok_nxt.hit   = 1'b1;
      dat_nxt[D_X0] = dat_i[D_LX];
      dat_nxt[D_Y0] = dat_i[D_LY];
      dat_nxt[D_X1] = x_r;
      dat_nxt[D_Y1] = y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
    if (wr_en) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end
  end

  assign tok_o = tok_r;
  assign dat_o = dat_r;

endmodule

@@ bench/btip_checker.sv @@
module btip_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_req_type,
  input  logic [3:0]                         in_point_index,
  input  logic signed [btip_pkg::VW_DEF-1:0] in_point_x,
  input  logic signed [btip_pkg::VW_DEF-1:0] in_point_y,
  input  logic signed [btip_pkg::VW_DEF-1:0] in_query_x,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [btip_pkg::VW_DEF-1:0] out_result_value,
  input  logic [1:0]                         out_range_status,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [3:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  input  logic                               cfg_pready,
  output int                                 fail_count,
  output int                                 pending
);
  import btip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VW_DEF-1:0] value;
    logic [1:0]               status;
  } lookup_t;

  logic signed [VW_DEF-1:0] tab_x [POINTS_DEF];
  logic signed [VW_DEF-1:0] tab_y [POINTS_DEF];
  logic [1:0]               mode;
  logic                     edge_zero;
  logic [4:0]               count;
  lookup_t                  lookup_q [$];

  function automatic longint lerp(longint x0, longint y0, longint x1, longint y1, longint x);
    longint span;
    longint dy;
    longint off;
    longint q;
    span = x1 - x0;
    dy   = y1 - y0;
    off  = x - x0;
    if (span <= 0 || off < 0) return y0;
    q = ((dy < 0 ? -dy : dy) * off) / span;
    return dy < 0 ? y0 - q : y0 + q;
  endfunction

  function automatic lookup_t evaluate(logic signed [VW_DEF-1:0] qx);
    lookup_t r;
    int      n;
    int      hit;
    longint  x;
    longint  x0;
    longint  x1;
    longint  v;
    n = count;
    if (n < 2) n = 2;
    if (n > POINTS_DEF) n = POINTS_DEF;
    x = qx;
    if (x <= tab_x[0]) begin
      r.status = RANGE_LOW;
      v = edge_zero ? 0 : tab_y[0];
    end else if (x > tab_x[n-1]) begin
      r.status = RANGE_HIGH;
      v = edge_zero ? 0 : tab_y[n-1];
    end else begin
      r.status = RANGE_IN;
      hit = 0;
      for (int i = 1; i < n; i++) begin
        if (hit == 0 && x < tab_x[i]) hit = i;
      end
      if (hit == 0) begin
        v = tab_y[n-1];
      end else begin
        x0 = tab_x[hit-1];
        x1 = tab_x[hit];
        case (mode)
          MODE_LEFT:    v = tab_y[hit-1];
          MODE_RIGHT:   v = tab_y[hit];
          MODE_NEAREST: v = (2 * x > x0 + x1) ? tab_y[hit] : tab_y[hit-1];
          default:      v = lerp(x0, tab_y[hit-1], x1, tab_y[hit], x);
        endcase
      end
    end
    r.value = v[VW_DEF-1:0];
    return r;
  endfunction

  assign pending = lookup_q.size();

  always_ff @(posedge clk) begin
    lookup_t e;
    if (!rst_n) begin
      mode       <= MODE_LINEAR;
      edge_zero  <= 1'b0;
      count      <= 5'd2;
      fail_count <= 0;
      lookup_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_INTERP: mode      <= cfg_pwdata[1:0];
          REG_EDGE:   edge_zero <= cfg_pwdata[0];
          REG_COUNT:  count     <= cfg_pwdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_WRITE) begin
          tab_x[in_point_index] <= in_point_x;
          tab_y[in_point_index] <= in_point_y;
        end else begin
          lookup_q.push_back(evaluate(in_query_x));
        end
      end
      if (out_valid && !out_stall) begin
        if (lookup_q.size() == 0) begin
          $display("%0t: unexpected word value %0d status %0d", $time,
                   out_result_value, out_range_status);
          fail_count <= fail_count + 1;
        end else begin
          e = lookup_q.pop_front();
          if (e.value !== out_result_value || e.status !== out_range_status) begin
            $display("%0t: mismatch expected value %0d status %0d, got value %0d status %0d",
                     $time, e.value, e.status, out_result_value, out_range_status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ bench/tb_breakpoint_table_interpolator_unit.sv @@
module tb_breakpoint_table_interpolator_unit;
  import btip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN = POINTS_DEF + 2 * VW_DEF + 10;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_req_type;
  logic [3:0]               in_point_index;
  logic signed [VW_DEF-1:0] in_point_x;
  logic signed [VW_DEF-1:0] in_point_y;
  logic signed [VW_DEF-1:0] in_query_x;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [VW_DEF-1:0] out_result_value;
  logic [1:0]               out_range_status;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [3:0]               cfg_paddr;
  logic [31:0]              cfg_pwdata;
  logic [31:0]              cfg_prdata;
  logic                     cfg_pready;
  int                       fail_count;
  int                       pending;

  int tx [POINTS_DEF];
  int cur_count;
  int n_queries;
  int n_writes;
  int n_cfg;
  int stall_left;

  breakpoint_table_interpolator_unit u_top (.*);

  btip_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(9))
        0, 1, 2: begin
          out_stall  <= 1'b1;
          stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(3);
        end
        3:       begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(100);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(4);
    return $urandom_range(40);
  endfunction

  task automatic send_word(logic t, int idx, int px, int py, int qx, bit gaps);
    int gap;
    in_valid       <= 1'b1;
    in_req_type    <= t;
    in_point_index <= idx[3:0];
    in_point_x     <= px[VW_DEF-1:0];
    in_point_y     <= py[VW_DEF-1:0];
    in_query_x     <= qx[VW_DEF-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (t == REQ_WRITE) begin
      n_writes++;
      tx[idx] = $signed(px[VW_DEF-1:0]);
    end else begin
      n_queries++;
    end
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] r, int v);
    in_valid    <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    n_cfg++;
    if (r == REG_COUNT) cur_count = v & 31;
  endtask

  task automatic load_table(int span);
    int x;
    int step;
    int y;
    x = -32768 + $urandom_range(span);
    for (int i = 0; i < POINTS_DEF; i++) begin
      y = $urandom_range(65535) - 32768;
      send_word(REQ_WRITE, i, x, y, $urandom_range(65535), 1'b1);
      step = 1 + $urandom_range(span);
      x = x + step;
    end
  endtask

  function automatic int active_n();
    int n;
    n = cur_count;
    if (n < 2) n = 2;
    if (n > POINTS_DEF) n = POINTS_DEF;
    return n;
  endfunction

  function automatic int pick_query();
    int n;
    int k;
    int lo;
    int hi;
    n = active_n();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(65535) - 32768;
      2, 3:    begin
        k = $urandom_range(n - 1);
        return tx[k] + $urandom_range(2) - 1;
      end
      4:       begin
        k = $urandom_range(n - 2);
        return (tx[k] + tx[k+1]) / 2 + $urandom_range(1);
      end
      default: begin
        lo = tx[0] - 64;
        hi = tx[n-1] + 64;
        if (hi < lo) return $urandom_range(65535) - 32768;
        return lo + $urandom_range(hi - lo);
      end
    endcase
  endfunction

  initial begin
    int counts [8];
    int n;
    counts = '{2, 16, 0, 1, 31, 5, 9, 3};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_WRITE;
    in_point_index = '0;
    in_point_x = '0;
    in_point_y = '0;
    in_query_x = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_count = 2;
    n_queries = 0;
    n_writes = 0;
    n_cfg = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_table(4000);
    cfg_write(REG_COUNT, 16);
    n = active_n();
    for (int m = 0; m < 4; m++) begin
      drain();
      cfg_write(REG_INTERP, m);
      cfg_write(REG_EDGE, m & 1);
      send_word(REQ_QUERY, 0, 0, 0, tx[0], 1'b0);
      send_word(REQ_QUERY, 0, 0, 0, tx[n-1], 1'b0);
      send_word(REQ_QUERY, 0, 0, 0, tx[n-1] + 1, 1'b0);
      send_word(REQ_QUERY, 0, 0, 0, (tx[3] + tx[4]) / 2, 1'b0);
      send_word(REQ_QUERY, 0, 0, 0, tx[5] + 1, 1'b0);
    end
    send_word(REQ_QUERY, 0, 0, 0, -32768, 1'b0);
    send_word(REQ_QUERY, 0, 0, 0, 32767, 1'b0);

    for (int ph = 0; ph < 16; ph++) begin
      drain();
      cfg_write(REG_INTERP, ph % 4);
      cfg_write(REG_EDGE, (ph / 4) % 2);
      cfg_write(REG_COUNT, counts[ph % 8]);
      if (ph % 3 == 0) load_table(($urandom_range(3) == 0) ? 4000 : 200);
      for (int k = 0; k < 90; k++) begin
        if (ph == 7 && k == 45) drain();
        if ($urandom_range(9) == 0)
          send_word(REQ_WRITE, $urandom_range(15), $urandom_range(65535),
                    $urandom_range(65535), $urandom_range(65535), 1'b1);
        else
          send_word(REQ_QUERY, $urandom_range(15), $urandom_range(65535),
                    $urandom_range(65535), pick_query(), ($urandom_range(7) != 0));
      end
    end

    drain();
    $display("covered %0d queries, %0d table writes, %0d register writes", n_queries,
             n_writes, n_cfg);
    $display("all four modes, both edge settings, point counts from 0 to 31");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/btip_pkg.sv
design/btip_cell.sv
design/breakpoint_table_interpolator_unit.sv
bench/btip_checker.sv
bench/tb_breakpoint_table_interpolator_unit.sv
